>>> sv/assert_macros.svh
// Assertion macros used by the RTL of the symmetric FIR filter unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication property on every rising clock edge outside reset.
`define SFIR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that an expression never becomes true outside reset.
`define SFIR_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define SFIR_ASSERT(lbl, clk, rstn, prop, msg)
`define SFIR_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

>>> sv/sfir_pkg.sv
// Shared constants, types and codes of the symmetric FIR filter unit.
// No dependencies; imported by every module of the block.
package sfir_pkg;

  // Field widths
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 16;
  localparam int TAPS_W         = 7;
  localparam int COEF_FRAC_BITS = 15;

  // Delay line and coefficient store geometry
  localparam int MAX_TAPS   = 64;
  localparam int TAP_AW     = $clog2(MAX_TAPS);
  localparam int CNT_W      = $clog2(MAX_TAPS + 1);
  localparam int HALF_DEPTH = (MAX_TAPS + 1) / 2;
  localparam int CIDX_W     = 5;
  localparam int STEP_W     = $clog2(HALF_DEPTH);
  localparam int NSTEP_W    = $clog2(HALF_DEPTH + 1);
  localparam int TAPS_RESET = 64;

  // Digit-serial multiply geometry
  localparam int SUM_W   = SAMPLE_W + 1;
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int SREG_W  = DIGITS * DIGIT_W;
  localparam int K_W     = $clog2(DIGITS);
  localparam int SH_W    = $clog2(SREG_W);
  localparam int PP_W    = COEF_W + DIGIT_W + 1;
  localparam int ACC_W   = COEF_W + SUM_W + $clog2(HALF_DEPTH) + 1;
  localparam int Y_W     = ACC_W - COEF_FRAC_BITS;
  localparam int OUT_MAX = 2 ** (SAMPLE_W - 1) - 1;

  // Input word commands
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // Read request for one step of the tap walk
  typedef struct packed {
    logic                en;
    logic [STEP_W-1:0]   step;
    logic [TAPS_W-1:0]   taps;
    logic                mid;
  } rd_req_t;

  // Operands of one step, as read from the stores
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] xa;
    logic signed [SAMPLE_W-1:0] xb;
    logic signed [COEF_W-1:0]   coef;
  } tap_data_t;

  // Controls of the multiply-accumulate unit
  typedef struct packed {
    logic           clr;
    logic           load;
    logic           step;
    logic [K_W-1:0] k;
  } mac_ctl_t;

endpackage

>>> sv/sfir_store.sv
// Delay line memory (circular, two registered read ports) and coefficient file.
// Depends on sfir_pkg.
module sfir_store import sfir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_sample_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       coef_we_i,
  input  logic [CIDX_W-1:0]          coef_index_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  input  rd_req_t                    rd_req_i,
  output tap_data_t                  data_o
);

  logic signed [SAMPLE_W-1:0] line_mem [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_q [HALF_DEPTH];

  logic [TAP_AW-1:0] head_q, head_d;
  logic [CNT_W-1:0]  fill_q, fill_d;

  logic [CNT_W-1:0]  age_a, age_b;
  logic [TAP_AW-1:0] addr_a, addr_b;
  logic              ok_a, ok_b;

  logic signed [SAMPLE_W-1:0] rd_a_q, rd_b_q;
  logic signed [COEF_W-1:0]   rd_coef_q;
  logic                       ok_a_q, ok_b_q;

  // Advance the head and the fill count on each new sample
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (wr_sample_i) begin
      head_d = head_q + TAP_AW'(1);
      if (fill_q != CNT_W'(MAX_TAPS)) begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // Write the newest sample one slot past the old head
  always_ff @(posedge clk_i) begin
    if (wr_sample_i) begin
      line_mem[head_d] <= sample_i;
    end
  end

  // Coefficient file, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < HALF_DEPTH; n++) begin
        coef_q[n] <= '0;
      end
    end else if (coef_we_i && (32'(coef_index_i) < HALF_DEPTH)) begin
      coef_q[coef_index_i[STEP_W-1:0]] <= coef_value_i;
    end
  end

  // Map the step to the ages of its mirrored pair; a slot never written reads as zero
  always_comb begin
    age_a  = CNT_W'(rd_req_i.step);
    age_b  = CNT_W'(rd_req_i.taps) - CNT_W'(1) - CNT_W'(rd_req_i.step);
    addr_a = head_q - age_a[TAP_AW-1:0];
    addr_b = head_q - age_b[TAP_AW-1:0];
    ok_a   = age_a < fill_q;
    ok_b   = (age_b < fill_q) && !rd_req_i.mid;
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_a_q    <= line_mem[addr_a];
      rd_b_q    <= line_mem[addr_b];
      rd_coef_q <= coef_q[rd_req_i.step];
      ok_a_q    <= ok_a;
      ok_b_q    <= ok_b;
    end
  end

  assign data_o.xa   = ok_a_q ? rd_a_q : '0;
  assign data_o.xb   = ok_b_q ? rd_b_q : '0;
  assign data_o.coef = rd_coef_q;

endmodule

>>> sv/sfir_mac.sv
// Digit-serial pre-add multiply-accumulate with floor and saturation.
// Depends on sfir_pkg.
module sfir_mac import sfir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctl_t                   ctl_i,
  input  tap_data_t                  data_i,
  output logic signed [SAMPLE_W-1:0] y_o,
  output logic                       sat_o
);

  localparam logic signed [Y_W-1:0] YMAX = Y_W'(OUT_MAX);
  localparam logic signed [Y_W-1:0] YMIN = Y_W'(-OUT_MAX - 1);

  logic signed [SREG_W-1:0] sum_q, sum_d;
  logic signed [COEF_W-1:0] coef_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  logic signed [DIGIT_W:0]  dig_s;
  logic signed [PP_W-1:0]   pp;
  logic signed [ACC_W-1:0]  pp_ext;
  logic [SH_W-1:0]          shamt;
  logic signed [Y_W-1:0]    y_full;

  // Low digits are unsigned, the top digit carries the sign
  always_comb begin
    if (ctl_i.k == K_W'(DIGITS - 1)) begin
      dig_s = {sum_q[DIGIT_W-1], sum_q[DIGIT_W-1:0]};
    end else begin
      dig_s = {1'b0, sum_q[DIGIT_W-1:0]};
    end
    pp     = coef_q * dig_s;
    pp_ext = ACC_W'(pp);
    shamt  = SH_W'(32'(ctl_i.k) * DIGIT_W);
  end

  // Pre-add the mirrored pair, then drop one digit per step
  always_comb begin
    sum_d = sum_q;
    acc_d = acc_q;
    if (ctl_i.load) begin
      sum_d = SREG_W'(data_i.xa) + SREG_W'(data_i.xb);
    end else if (ctl_i.step) begin
      sum_d = sum_q >>> DIGIT_W;
      acc_d = acc_q + (pp_ext <<< shamt);
    end
    if (ctl_i.clr) begin
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (ctl_i.load) begin
      coef_q <= data_i.coef;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Floor by the coefficient scale and clip to the sample range
  always_comb begin
    y_full = Y_W'(acc_q >>> COEF_FRAC_BITS);
    if (y_full > YMAX) begin
      y_o   = SAMPLE_W'(YMAX);
      sat_o = 1'b1;
    end else if (y_full < YMIN) begin
      y_o   = SAMPLE_W'(YMIN);
      sat_o = 1'b1;
    end else begin
      y_o   = y_full[SAMPLE_W-1:0];
      sat_o = 1'b0;
    end
  end

endmodule

>>> sv/symmetric_fir_filter_unit.sv
// Symmetric linear-phase FIR filter: one filter word (cmd 0) gives one output word,
// a load word (cmd 1) writes one half-coefficient. A filter word walks ceil(T/2)
// steps, T being the active tap count clamped to 2..64; each step reads a mirrored
// sample pair and its coefficient, pre-adds the pair and multiplies the sum four bits
// at a time over five digits. The next word is taken once the current one sits in
// the output register.
// Depends on sfir_pkg, sfir_store, sfir_mac and assert_macros.svh.
`include "assert_macros.svh"

module symmetric_fir_filter_unit import sfir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input words
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic [CIDX_W-1:0]          coef_index_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  // Result words
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] filtered_sample_o,
  output logic                       saturated_o,
  // Tap count register
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [TAPS_W-1:0]          cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [TAPS_W-1:0]   taps_q;
  logic [TAPS_W-1:0]   t_q, t_d;
  logic [STEP_W-1:0]   i_q, i_d;
  logic [K_W-1:0]      k_q, k_d;
  logic [NSTEP_W-1:0]  nsteps;
  logic                last_step;
  logic                in_fire, filt_fire, load_fire, out_take;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_sat_q;

  rd_req_t                    rd_req;
  tap_data_t                  tap_data;
  mac_ctl_t                   mac_ctl;
  logic signed [SAMPLE_W-1:0] mac_y;
  logic                       mac_sat;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign filt_fire   = in_fire && (cmd_i == CMD_FILTER);
  assign load_fire   = in_fire && (cmd_i == CMD_LOAD);
  assign cfg_ready_o = 1'b1;

  // Hold the tap count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TAPS_W'(TAPS_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      taps_q <= cfg_data_i;
    end
  end

  // Step count is ceil(T/2); the odd middle tap is the last step
  assign nsteps    = NSTEP_W'(t_q[TAPS_W-1:1]) + NSTEP_W'(t_q[0]);
  assign last_step = (NSTEP_W'(i_q) + NSTEP_W'(1)) == nsteps;

  // Sequence the tap walk
  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    i_d     = i_q;
    k_d     = k_q;
    out_take = 1'b0;
    rd_req.en   = 1'b0;
    rd_req.step = '0;
    rd_req.taps = t_q;
    mac_ctl.clr  = 1'b0;
    mac_ctl.load = 1'b0;
    mac_ctl.step = 1'b0;
    mac_ctl.k    = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (filt_fire) begin
          if (taps_q < TAPS_W'(2)) begin
            t_d = TAPS_W'(2);
          end else if (taps_q > TAPS_W'(MAX_TAPS)) begin
            t_d = TAPS_W'(MAX_TAPS);
          end else begin
            t_d = taps_q;
          end
          i_d         = '0;
          mac_ctl.clr = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        rd_req.en   = 1'b1;
        rd_req.step = '0;
        state_d     = S_LOAD;
      end
      S_LOAD: begin
        mac_ctl.load = 1'b1;
        rd_req.en    = !last_step;
        rd_req.step  = i_q + STEP_W'(1);
        k_d          = '0;
        state_d      = S_MUL;
      end
      S_MUL: begin
        mac_ctl.step = 1'b1;
        k_d          = k_q + K_W'(1);
        if (k_q == K_W'(DIGITS - 1)) begin
          if (last_step) begin
            state_d = S_DONE;
          end else begin
            i_d     = i_q + STEP_W'(1);
            state_d = S_LOAD;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_take = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    rd_req.mid = t_q[0] && (NSTEP_W'(rd_req.step) == NSTEP_W'(t_q[TAPS_W-1:1]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      t_q     <= TAPS_W'(TAPS_RESET);
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

  // Output register: hold a word until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_sample_q <= mac_y;
      out_sat_q    <= mac_sat;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_sample_q;
  assign saturated_o       = out_sat_q;

  sfir_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_sample_i  (filt_fire),
    .sample_i     (sample_in_i),
    .coef_we_i    (load_fire),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .rd_req_i     (rd_req),
    .data_o       (tap_data)
  );

  sfir_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .data_i (tap_data),
    .y_o    (mac_y),
    .sat_o  (mac_sat)
  );

  // Checks on the sequencer
  `SFIR_ASSERT(a_filt_starts_walk, clk_i, rst_ni, filt_fire |=> (state_q == S_READ), "filter word did not start the tap walk")
  `SFIR_NEVER(a_step_in_range, clk_i, rst_ni, (state_q == S_MUL) && (NSTEP_W'(i_q) >= nsteps), "step index ran past the last step")
  `SFIR_ASSERT(a_done_holds, clk_i, rst_ni, ((state_q == S_DONE) && out_valid_q && !out_ready_i) |=> (state_q == S_DONE), "finished word dropped while output register full")
  `SFIR_ASSERT(a_take_sets_valid, clk_i, rst_ni, out_take |=> out_valid_q, "result not presented after finish")

endmodule

>>> test/tb_top.sv
// Self-checking testbench for symmetric_fir_filter_unit: drives filter and coefficient-load
// words, predicts every filtered word in-line and compares it with the block's output.
// Depends on sfir_pkg and the RTL of the block.
module tb_top;
  import sfir_pkg::*;

  localparam int PHASE_WORDS    = 75;
  localparam int DRAIN_CYCLES   = 220;
  localparam int HOLD_CYCLES    = 800;
  localparam int HOLD_AT_RESULT = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CIDX_W-1:0]          cidx;
    logic signed [COEF_W-1:0]   cval;
  } fir_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sat;
  } fir_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       cmd_i = CMD_FILTER;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic [CIDX_W-1:0]          coef_index_i = '0;
  logic signed [COEF_W-1:0]   coef_value_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered_sample_o;
  logic                       saturated_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [TAPS_W-1:0]          cfg_data_i = '0;

  // Predictor state
  logic [TAPS_W-1:0]          taps_reg = TAPS_W'(TAPS_RESET);
  logic signed [SAMPLE_W-1:0] delay_mem [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_mem [HALF_DEPTH];

  fir_word_t   in_word_q[$];
  fir_result_t expected_out_q[$];

  logic in_taken = 1'b0;
  int   idle_pct = 6;
  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_results = 0;
  int   n_errors = 0;
  int   n_filters = 0;
  int   n_loads = 0;
  int   n_cfg = 0;
  int   n_sat = 0;
  int   n_odd = 0;
  int   hold_left = 0;
  logic held_once = 1'b0;
  int   quiet_cycles = 0;

  wire any_fire = (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                  (cfg_valid_i && cfg_ready_o);

  symmetric_fir_filter_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .sample_in_i       (sample_in_i),
    .coef_index_i      (coef_index_i),
    .coef_value_i      (coef_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .filtered_sample_o (filtered_sample_o),
    .saturated_o       (saturated_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Apply one accepted word to the predictor and queue the filter output it yields
  task automatic predict_word(input fir_word_t w);
    longint      acc;
    longint      y;
    int          t;
    fir_result_t r;
    if (w.cmd == CMD_LOAD) begin
      if (w.cidx < HALF_DEPTH) coef_mem[w.cidx] = w.cval;
      n_loads++;
    end else begin
      for (int i = MAX_TAPS - 1; i > 0; i--) delay_mem[i] = delay_mem[i-1];
      delay_mem[0] = w.sample;
      t = (taps_reg < 2) ? 2 : (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
      acc = 0;
      for (int i = 0; i < t / 2; i++) begin
        acc += longint'(coef_mem[i]) *
               (longint'(delay_mem[i]) + longint'(delay_mem[t-1-i]));
      end
      // Odd tap count: add the middle tap once
      if (t % 2 == 1) begin
        acc += longint'(coef_mem[(t-1)/2]) * longint'(delay_mem[(t-1)/2]);
        n_odd++;
      end
      // Floor the Q1.15 scaling, then clip to 16 bits
      y = acc >>> COEF_FRAC_BITS;
      r.sat = 1'b0;
      if (y > OUT_MAX) begin
        y = OUT_MAX;
        r.sat = 1'b1;
      end else if (y < -OUT_MAX - 1) begin
        y = -OUT_MAX - 1;
        r.sat = 1'b1;
      end
      r.sample = y[SAMPLE_W-1:0];
      expected_out_q.push_back(r);
      n_filters++;
    end
  endtask

  task automatic push_word(input logic cmd, input logic [SAMPLE_W-1:0] s,
                           input logic [CIDX_W-1:0] ci, input logic [COEF_W-1:0] cv);
    fir_word_t w;
    w.cmd = cmd;
    w.sample = s;
    w.cidx = ci;
    w.cval = cv;
    in_word_q.push_back(w);
    n_queued++;
  endtask

  // Wait until every word is taken and every output has arrived, then let the block settle
  task automatic wait_idle();
    while (n_accepted != n_queued || expected_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_taps(input logic [TAPS_W-1:0] v);
    @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Input driver: offer the next pending word once the current one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (in_word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cmd_i        <= in_word_q[0].cmd;
        sample_in_i  <= in_word_q[0].sample;
        coef_index_i <= in_word_q[0].cidx;
        coef_value_i <= in_word_q[0].cval;
        void'(in_word_q.pop_front());
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!held_once && n_results == HOLD_AT_RESULT) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: track config writes, predict on accepted words, check output words
  always @(posedge clk_i) begin
    fir_word_t   w;
    fir_result_t r;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        taps_reg = cfg_data_i;
        n_cfg++;
      end
      if (in_valid_i && in_ready_o) begin
        w.cmd = cmd_i;
        w.sample = sample_in_i;
        w.cidx = coef_index_i;
        w.cval = coef_value_i;
        predict_word(w);
        n_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (saturated_o === 1'b1) n_sat++;
        if (expected_out_q.size() == 0) begin
          report_mismatch($sformatf("output word %0d with none expected", filtered_sample_o));
        end else begin
          r = expected_out_q.pop_front();
          if (filtered_sample_o !== r.sample)
            report_mismatch($sformatf("filtered_sample %0d, expected %0d",
                                      filtered_sample_o, r.sample));
          if (saturated_o !== r.sat)
            report_mismatch($sformatf("saturated %b, expected %b", saturated_o, r.sat));
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || any_fire) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int tap_settings[$];
    int kind;
    int s_val;
    int c_val;
    tap_settings = '{5, 0, 1, 2, 3, 127, 65, 64, 33, 16};
    tap_settings.push_back(2 * $urandom_range(2, 31) + 1);
    tap_settings.push_back(2 * $urandom_range(2, 31));
    foreach (delay_mem[i]) delay_mem[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: full-scale coefficients, saturation both ways, bit patterns
    push_word(CMD_LOAD, 16'h0000, 5'd0, 16'sh7fff);
    push_word(CMD_LOAD, 16'hffff, 5'd1, 16'sh7fff);
    push_word(CMD_LOAD, 16'h0000, 5'd2, 16'sh7fff);
    push_word(CMD_LOAD, 16'hffff, 5'd31, 16'sh8000);
    repeat (4) push_word(CMD_FILTER, 16'sh7fff, 5'd31, 16'hffff);
    repeat (4) push_word(CMD_FILTER, 16'sh8000, 5'd0, 16'h0000);
    push_word(CMD_FILTER, 16'sh0000, 5'h15, 16'h5555);
    push_word(CMD_FILTER, 16'shffff, 5'h0a, 16'haaaa);
    push_word(CMD_FILTER, 16'sh0001, 5'd0, 16'h0000);
    push_word(CMD_LOAD, 16'h5555, 5'd15, 16'shffff);
    push_word(CMD_LOAD, 16'haaaa, 5'd16, 16'sh0001);
    push_word(CMD_FILTER, 16'sh5555, 5'd0, 16'h0000);
    push_word(CMD_FILTER, 16'shaaaa, 5'd0, 16'h0000);
    for (int k = 0; k < 32; k++) push_word(CMD_FILTER, 16'sh7fff, 5'd0, 16'h0000);

    // Random phases, one per tap setting
    foreach (tap_settings[p]) begin
      wait_idle();
      write_taps(TAPS_W'(tap_settings[p]));
      idle_pct = (tap_settings[p] == 16) ? 0 : 6;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        kind = $urandom_range(99);
        if ($urandom_range(1)) c_val = int'($urandom_range(4095)) - 2048;
        else c_val = $urandom;
        if (kind < 10) s_val = $urandom_range(1) ? 32767 : -32768;
        else if (kind < 50) s_val = int'($urandom_range(8191)) - 4096;
        else s_val = $urandom;
        if ($urandom_range(99) < 20)
          push_word(CMD_LOAD, SAMPLE_W'($urandom), CIDX_W'($urandom), COEF_W'(c_val));
        else
          push_word(CMD_FILTER, SAMPLE_W'(s_val), CIDX_W'($urandom), COEF_W'($urandom));
      end
    end
    wait_idle();

    if (expected_out_q.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", expected_out_q.size()));
    $display("Run covered %0d filter words and %0d coefficient loads over %0d tap settings,",
             n_filters, n_loads, n_cfg);
    $display("with %0d words under odd tap counts and %0d saturated outputs; %0d mismatches.",
             n_odd, n_sat, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
